FILE: sv/tnot_pkg.sv
`default_nettype none
package tnot_pkg;
	localparam int SLOTS_DEFAULT = 16;
	localparam logic [23:0] MIN_ANG_RESET = 24'd33554;

	localparam logic [1:0] KIND_SUBMIT = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [3:0] ACT_INVALID  = 4'd0;
	localparam logic [3:0] ACT_CULLED   = 4'd1;
	localparam logic [3:0] ACT_MERGED   = 4'd2;
	localparam logic [3:0] ACT_APPENDED = 4'd3;
	localparam logic [3:0] ACT_REPLACED = 4'd4;
	localparam logic [3:0] ACT_DROPPED  = 4'd5;
	localparam logic [3:0] ACT_CLEARED  = 4'd6;
	localparam logic [3:0] ACT_READ     = 4'd7;
	localparam logic [3:0] ACT_READ_OOR = 4'd8;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0] radius;
		logic [15:0] name;
		logic [31:0] prio;
	} entry_t;

	// Token passed down the cell chain during a scan.
	typedef struct packed {
		logic        vld;
		logic        found;
		logic [5:0]  match_idx;
		logic [5:0]  min_idx;
		logic [31:0] min_prio;
		entry_t      data;
	} token_t;
endpackage
`default_nettype wire

FILE: sv/tnot_div.sv
`default_nettype none
module tnot_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [31:0]      quot
);
	// Restoring divide of num*2^24 by den, one quotient bit a cycle.
	// Quotient bits above 32 only mark saturation.
	logic [55:0] dividend_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [31:0] q_q;
	logic        sat_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, dividend_q[55]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd55;
			end else if (run_q) begin
				if (cnt_q == 6'd0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// The remainder always stays below den, so it fits in 32 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {num, 24'd0};
			rem_q <= '0;
			den_q <= den;
			q_q <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			dividend_q <= {dividend_q[54:0], 1'b0};
			rem_q <= ge ? diff[31:0] : trial[31:0];
			q_q <= {q_q[30:0], ge};
			sat_q <= sat_q | (ge & q_q[31]);
			if (ge && cnt_q >= 6'd32) sat_q <= 1'b1;
		end
	end

	assign quot = sat_q ? 32'hFFFF_FFFF : q_q;
endmodule
`default_nettype wire

FILE: sv/tnot_cell.sv
`default_nettype none
module tnot_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              active,
	input  wire tnot_pkg::token_t  tin,
	input  wire logic              wr,
	input  wire logic [5:0]        wr_idx,
	input  wire tnot_pkg::entry_t  wr_data,
	output tnot_pkg::token_t       tout,
	output tnot_pkg::entry_t       held
);
	// Each cell holds one entry and compares it against the token as it passes.
	tnot_pkg::entry_t e_q;
	tnot_pkg::token_t t_q;
	logic hit;

	assign held = e_q;
	assign hit = active && ((tin.data.name != 16'd0 && e_q.name == tin.data.name) ||
		(e_q.x == tin.data.x && e_q.y == tin.data.y && e_q.z == tin.data.z &&
		 e_q.radius == tin.data.radius));

	always_ff @(posedge clk) begin
		if (wr && wr_idx == 6'(IDX)) e_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else begin
			t_q.vld <= tin.vld;
			t_q.data <= tin.data;
			t_q.found <= tin.found | hit;
			t_q.match_idx <= (!tin.found && hit) ? 6'(IDX) : tin.match_idx;
			if (IDX == 0 || e_q.prio < tin.min_prio) begin
				t_q.min_idx <= 6'(IDX);
				t_q.min_prio <= e_q.prio;
			end else begin
				t_q.min_idx <= tin.min_idx;
				t_q.min_prio <= tin.min_prio;
			end
		end
	end

	assign tout = t_q;
endmodule
`default_nettype wire

FILE: sv/top_n_occluder_table_core.sv
// top_n_occluder_table_core keeps the highest-priority bodies of a frame.
// Command channel: assert start with kind and the payload fields; the item is
// taken on an edge where start is high and busy is low. busy stays high until
// the result is presented. Each item gives one result, on the result ports
// for one cycle with done high; the receiver cannot stall and must take it.
// Submit (kind 0) passes the check and the bit-serial priority divide, then
// the token walks the cell chain, which holds one entry per cell and finds
// the first match and the minimum on the way; a final state writes the table.
// Clear, read and rejected submits are answered from the check state.
// The next item can be taken at the edge that ends the result cycle.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the cull
// threshold; it is always ready and should be written only while idle.
// Reset empties the table and loads the default threshold of 0.002.
// Slot contents are undefined after reset until written.
`default_nettype none
module top_n_occluder_table_core #(
	parameter int SLOTS = tnot_pkg::SLOTS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0]        body_radius,
	input  wire logic [31:0]        cam_distance,
	input  wire logic [15:0]        name_id,
	input  wire logic [5:0]         read_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [23:0]        cfg_data,
	output logic                    done,
	output logic [3:0]              action,
	output logic [5:0]              slot,
	output logic [6:0]              entry_count,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic [31:0]             out_radius,
	output logic [15:0]             out_name,
	output logic [31:0]             out_priority
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [2:0]  st_q;
	logic [23:0] thr_q;
	logic [6:0]  cnt_q;
	logic [1:0]  kind_q;
	logic        culled_q;
	tnot_pkg::entry_t in_q;
	logic [31:0] dist_q;
	logic [5:0]  ridx_q;
	logic [55:0] lhs;
	logic [55:0] rhs;
	logic        div_start, div_done;
	logic [31:0] quot;

	tnot_pkg::token_t chain [SLOTS+1];
	tnot_pkg::entry_t held [SLOTS];
	tnot_pkg::token_t res_q;
	logic        wr;
	logic [5:0]  wr_idx;
	tnot_pkg::entry_t wr_data;
	tnot_pkg::entry_t rd;

	assign cfg_ready = 1'b1;
	assign busy = st_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= tnot_pkg::MIN_ANG_RESET;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	assign lhs = {body_radius, 24'd0};
	assign rhs = 56'(cam_distance) * 56'(thr_q);

	tnot_div u_div (.clk, .arst_n, .start(div_start), .num(in_q.radius),
		.den(dist_q), .done(div_done), .quot);

	assign chain[0].vld = div_done;
	assign chain[0].found = 1'b0;
	assign chain[0].match_idx = '0;
	assign chain[0].min_idx = '0;
	assign chain[0].min_prio = '0;
	assign chain[0].data = '{x: in_q.x, y: in_q.y, z: in_q.z, radius: in_q.radius,
		name: in_q.name, prio: quot};

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		tnot_cell #(.IDX(g)) u_cell (.clk, .arst_n,
			.active(7'(g) < cnt_q), .tin(chain[g]), .wr, .wr_idx, .wr_data,
			.tout(chain[g+1]), .held(held[g]));
	end

	// Reads are only used when the index is below the fill count.
	assign rd = held[ridx_q[IW-1:0]];

	// Write port to cells, derived from the finished scan token.
	always_comb begin
		tnot_pkg::entry_t m;
		m = held[res_q.match_idx[IW-1:0]];
		wr = 1'b0;
		wr_idx = '0;
		wr_data = res_q.data;
		if (st_q == ST_FIN) begin
			if (res_q.found) begin
				wr = 1'b1;
				wr_idx = res_q.match_idx;
				wr_data = m;
				if (res_q.data.prio > m.prio) wr_data.prio = res_q.data.prio;
				if (res_q.data.name != 16'd0 && m.name == 16'd0)
					wr_data.name = res_q.data.name;
				if (res_q.data.prio >= m.prio) begin
					wr_data.x = res_q.data.x;
					wr_data.y = res_q.data.y;
					wr_data.z = res_q.data.z;
				end
			end else if (cnt_q < 7'(SLOTS)) begin
				wr = 1'b1;
				wr_idx = cnt_q[5:0];
			end else if (res_q.data.prio > res_q.min_prio) begin
				wr = 1'b1;
				wr_idx = res_q.min_idx;
			end
		end
	end

	assign div_start = st_q == ST_CHK && !culled_q &&
		kind_q == tnot_pkg::KIND_SUBMIT && in_q.radius != 32'd0 && dist_q != 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) st_q <= ST_CHK;
				ST_CHK: begin
					if (div_start) st_q <= ST_DIV;
					else begin
						st_q <= ST_IDLE;
						done <= 1'b1;
						if (kind_q == tnot_pkg::KIND_CLEAR) cnt_q <= '0;
					end
				end
				ST_DIV: if (div_done) st_q <= ST_SCAN;
				ST_SCAN: if (chain[SLOTS].vld) st_q <= ST_FIN;
				ST_FIN: begin
					st_q <= ST_IDLE;
					done <= 1'b1;
					if (!res_q.found && cnt_q < 7'(SLOTS)) cnt_q <= cnt_q + 7'd1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			kind_q <= kind;
			in_q <= '{x: pos_x, y: pos_y, z: pos_z, radius: body_radius,
				name: name_id, prio: 32'd0};
			dist_q <= cam_distance;
			ridx_q <= read_index;
			culled_q <= kind == tnot_pkg::KIND_SUBMIT && body_radius != 32'd0 &&
				cam_distance != 32'd0 && lhs < rhs;
		end
		if (chain[SLOTS].vld) res_q <= chain[SLOTS];
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (st_q == ST_CHK && !div_start) begin
			slot <= '0; entry_count <= cnt_q;
			out_x <= '0; out_y <= '0; out_z <= '0;
			out_radius <= '0; out_name <= '0; out_priority <= '0;
			if (kind_q == tnot_pkg::KIND_CLEAR) begin
				action <= tnot_pkg::ACT_CLEARED;
				entry_count <= '0;
			end else if (kind_q == tnot_pkg::KIND_READ) begin
				if (7'(ridx_q) < cnt_q) begin
					action <= tnot_pkg::ACT_READ;
					slot <= ridx_q;
					out_x <= rd.x; out_y <= rd.y; out_z <= rd.z;
					out_radius <= rd.radius; out_name <= rd.name;
					out_priority <= rd.prio;
				end else action <= tnot_pkg::ACT_READ_OOR;
			end else if (kind_q == tnot_pkg::KIND_SUBMIT && culled_q) begin
				action <= tnot_pkg::ACT_CULLED;
			end else begin
				action <= tnot_pkg::ACT_INVALID;
			end
		end else if (st_q == ST_FIN) begin
			out_x <= '0; out_y <= '0; out_z <= '0;
			out_radius <= '0; out_name <= '0;
			out_priority <= res_q.data.prio;
			entry_count <= cnt_q;
			slot <= wr_idx;
			if (res_q.found) action <= tnot_pkg::ACT_MERGED;
			else if (cnt_q < 7'(SLOTS)) begin
				action <= tnot_pkg::ACT_APPENDED;
				entry_count <= cnt_q + 7'd1;
			end else if (wr) action <= tnot_pkg::ACT_REPLACED;
			else action <= tnot_pkg::ACT_DROPPED;
		end
	end
endmodule
`default_nettype wire

FILE: test/top_n_occluder_table_core_tb.sv
`default_nettype none
module top_n_occluder_table_core_tb;
	localparam logic [1:0] KIND_UNDEF = 2'd3;
	localparam int NSLOT = 16;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] x, y, z, rad, cdist;
		logic [15:0] name;
		logic [5:0]  ridx;
	} body_cmd_t;

	typedef struct {
		logic [3:0]  action;
		logic [5:0]  slot;
		logic [6:0]  count;
		logic [31:0] x, y, z, rad;
		logic [15:0] name;
		logic [31:0] prio;
	} table_reply_t;

	class occluder_scoreboard;
		logic [23:0]  thr;
		int           fill;
		logic [31:0]  ex[NSLOT], ey[NSLOT], ez[NSLOT], er[NSLOT], ep[NSLOT];
		logic [15:0]  en[NSLOT];
		table_reply_t replies[$];
		int           errors;

		function new();
			thr = tnot_pkg::MIN_ANG_RESET;
			fill = 0;
			errors = 0;
		endfunction

		function void store(int i, body_cmd_t c, logic [31:0] p);
			ex[i] = c.x; ey[i] = c.y; ez[i] = c.z;
			er[i] = c.rad; en[i] = c.name; ep[i] = p;
		endfunction

		// Computes the reply for an accepted command and updates the table copy.
		function void note_command(body_cmd_t c);
			table_reply_t r;
			logic [63:0]  num, q;
			logic [31:0]  p;
			int           w;
			bit           hit;
			r = '{default: '0};
			if (c.kind == tnot_pkg::KIND_SUBMIT) begin
				num = {8'd0, c.rad, 24'd0};
				if (c.rad == 0 || c.cdist == 0)
					r.action = tnot_pkg::ACT_INVALID;
				else if (num < 64'(c.cdist) * 64'(thr))
					r.action = tnot_pkg::ACT_CULLED;
				else begin
					q = num / 64'(c.cdist);
					p = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
					r.prio = p;
					hit = 0;
					for (int i = 0; i < fill && !hit; i++) begin
						if ((c.name != 0 && en[i] == c.name) ||
						    (ex[i] == c.x && ey[i] == c.y && ez[i] == c.z && er[i] == c.rad)) begin
							hit = 1;
							if (p > ep[i]) ep[i] = p;
							if (c.name != 0 && en[i] == 0) en[i] = c.name;
							if (p >= ep[i]) begin
								ex[i] = c.x; ey[i] = c.y; ez[i] = c.z;
							end
							r.action = tnot_pkg::ACT_MERGED;
							r.slot = 6'(i);
						end
					end
					if (!hit) begin
						if (fill < NSLOT) begin
							store(fill, c, p);
							r.action = tnot_pkg::ACT_APPENDED;
							r.slot = 6'(fill);
							fill++;
						end else begin
							w = 0;
							for (int i = 1; i < NSLOT; i++)
								if (ep[i] < ep[w]) w = i;
							if (p > ep[w]) begin
								store(w, c, p);
								r.action = tnot_pkg::ACT_REPLACED;
								r.slot = 6'(w);
							end else
								r.action = tnot_pkg::ACT_DROPPED;
						end
					end
				end
			end else if (c.kind == tnot_pkg::KIND_CLEAR) begin
				fill = 0;
				r.action = tnot_pkg::ACT_CLEARED;
			end else if (c.kind == tnot_pkg::KIND_READ) begin
				if (c.ridx < fill) begin
					r.action = tnot_pkg::ACT_READ;
					r.slot = c.ridx;
					r.x = ex[c.ridx]; r.y = ey[c.ridx]; r.z = ez[c.ridx];
					r.rad = er[c.ridx]; r.name = en[c.ridx]; r.prio = ep[c.ridx];
				end else
					r.action = tnot_pkg::ACT_READ_OOR;
			end else
				r.action = tnot_pkg::ACT_INVALID;
			r.count = 7'(fill);
			replies.push_back(r);
		endfunction

		function void compare(string f, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, f, e, a);
			end
		endfunction

		function void check_reply(table_reply_t a);
			table_reply_t e;
			if (replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, action %h", $time, a.action);
				return;
			end
			e = replies.pop_front();
			compare("action", 32'(e.action), 32'(a.action));
			compare("slot", 32'(e.slot), 32'(a.slot));
			compare("entry_count", 32'(e.count), 32'(a.count));
			compare("out_x", e.x, a.x);
			compare("out_y", e.y, a.y);
			compare("out_z", e.z, a.z);
			compare("out_radius", e.rad, a.rad);
			compare("out_name", 32'(e.name), 32'(a.name));
			compare("out_priority", e.prio, a.prio);
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [1:0] kind;
	logic signed [31:0] pos_x, pos_y, pos_z, out_x, out_y, out_z;
	logic [31:0] body_radius, cam_distance, out_radius, out_priority;
	logic [15:0] name_id, out_name;
	logic [5:0] read_index, slot;
	logic [23:0] cfg_data;
	logic [3:0] action;
	logic [6:0] entry_count;

	occluder_scoreboard sb;
	int idle_cycles;
	logic [31:0] pool_x[4], pool_y[4], pool_z[4], pool_r[4];

	top_n_occluder_table_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .body_radius(body_radius),
		.cam_distance(cam_distance), .name_id(name_id), .read_index(read_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .action(action), .slot(slot), .entry_count(entry_count),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_radius(out_radius),
		.out_name(out_name), .out_priority(out_priority)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Result capture and the stall watchdog.
	always @(posedge clk) begin
		table_reply_t a;
		if (arst_n) begin
			if (done) begin
				a.action = action; a.slot = slot; a.count = entry_count;
				a.x = out_x; a.y = out_y; a.z = out_z; a.rad = out_radius;
				a.name = out_name; a.prio = out_priority;
				sb.check_reply(a);
			end
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("top_n_occluder_table_core verification failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic pause_random();
		int n, r;
		r = $urandom_range(0, 99);
		if (r < 60) n = 0;
		else if (r < 95) n = $urandom_range(1, 4);
		else n = $urandom_range(20, 90);
		repeat (n) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send(body_cmd_t c);
		start = 1;
		kind = c.kind;
		pos_x = c.x; pos_y = c.y; pos_z = c.z;
		body_radius = c.rad; cam_distance = c.cdist;
		name_id = c.name; read_index = c.ridx;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(c);
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		while (sb.replies.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_threshold(logic [23:0] v);
		drain();
		cfg_valid = 1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.thr = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic body_cmd_t body(logic [31:0] x, logic [31:0] r, logic [31:0] d,
	                                   logic [15:0] n);
		body_cmd_t c;
		c = '{kind: tnot_pkg::KIND_SUBMIT, x: x, y: ~x, z: x ^ 32'h5A5A_0000, rad: r,
		      cdist: d, name: n, ridx: '0};
		return c;
	endfunction

	function automatic body_cmd_t other(logic [1:0] k, logic [5:0] i);
		body_cmd_t c;
		c = '{default: '0};
		c.kind = k;
		c.ridx = i;
		return c;
	endfunction

	function automatic body_cmd_t random_cmd();
		body_cmd_t c;
		int r, p;
		c = '{default: '0};
		r = $urandom_range(0, 99);
		c.ridx = 6'($urandom_range(0, 63));
		if (r < 3) c.kind = tnot_pkg::KIND_CLEAR;
		else if (r < 20) c.kind = tnot_pkg::KIND_READ;
		else if (r < 23) c.kind = KIND_UNDEF;
		else c.kind = tnot_pkg::KIND_SUBMIT;
		c.x = $urandom; c.y = $urandom; c.z = $urandom;
		r = $urandom_range(0, 9);
		c.name = (r < 4) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 12)) : 16'($urandom);
		c.rad = $urandom_range(1, 1000);
		if ($urandom_range(0, 3) == 0) begin
			p = $urandom_range(0, 3);
			c.x = pool_x[p]; c.y = pool_y[p]; c.z = pool_z[p]; c.rad = pool_r[p];
		end
		c.cdist = $urandom_range(1, c.rad * 600);
		r = $urandom_range(0, 19);
		if (r == 0) c.rad = 0;
		else if (r == 1) c.cdist = 0;
		else if (r < 4) begin
			c.rad = $urandom;
			c.cdist = $urandom;
		end else if (r == 4)
			c.cdist = $urandom_range(1, 3);
		return c;
	endfunction

	initial begin
		logic [23:0] thresholds[5];
		sb = new();
		idle_cycles = 0;
		arst_n = 0;
		start = 0; kind = tnot_pkg::KIND_SUBMIT; cfg_valid = 0; cfg_data = '0;
		pos_x = 0; pos_y = 0; pos_z = 0; body_radius = 0; cam_distance = 0;
		name_id = 0; read_index = 0;
		for (int i = 0; i < 4; i++) begin
			pool_x[i] = $urandom; pool_y[i] = $urandom; pool_z[i] = $urandom;
			pool_r[i] = $urandom_range(1, 1000);
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: rejection, culling, saturation, merges, reads, clear, full table.
		send(body(32'h8000_0000, 0, 100, 0));
		send(body(32'h7FFF_FFFF, 100, 0, 0));
		send(body(1, 1, 1000, 0));
		send(body(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'hFFFF));
		send(body(2, 10, 100, 0));
		send(body(3, 10, 50, 16'hFFFF));
		send(body(2, 10, 20, 7));
		send(other(tnot_pkg::KIND_READ, 0));
		send(other(tnot_pkg::KIND_READ, 1));
		send(other(tnot_pkg::KIND_READ, 63));
		send(other(KIND_UNDEF, 0));
		send(other(tnot_pkg::KIND_CLEAR, 0));
		send(other(tnot_pkg::KIND_READ, 0));
		for (int i = 0; i < NSLOT; i++)
			send(body(32'(100 + i), 32'(10 + i), 1000, 16'(100 + i)));
		send(body(500, 5, 1000, 0));
		send(body(501, 50, 1000, 0));
		send(other(tnot_pkg::KIND_READ, 15));

		thresholds = '{tnot_pkg::MIN_ANG_RESET, 24'd0, 24'hFF_FFFF, 24'($urandom), 24'd1000};
		foreach (thresholds[ph]) begin
			write_threshold(thresholds[ph]);
			for (int n = 0; n < 250; n++) begin
				pause_random();
				if (n == 125) drain();
				send(random_cmd());
			end
		end

		drain();
		if (sb.errors == 0)
			$display("top_n_occluder_table_core verification clean");
		else
			$display("top_n_occluder_table_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire
